[rtl/per_cell_period_mean_sum_defines.svh]
// Assertion helpers for the per-cell aggregator
`ifndef PER_CELL_PERIOD_MEAN_SUM_DEFINES_SVH
`define PER_CELL_PERIOD_MEAN_SUM_DEFINES_SVH

// same-cycle implication
`define PCPMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcpms assertion failed");

// next-cycle implication
`define PCPMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcpms assertion failed");

`endif

[rtl/pcpms_pkg.sv]
package pcpms_pkg;

    localparam int CELL_W        = 12;
    localparam int VAL_W         = 32;
    localparam int SUM_W         = 48;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_CELLS_DEF = 4096;
    localparam int COUNT_MAX_DEF = 511;

    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic MODE_AVG = 1'b0;
    localparam logic MODE_SUM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING  = 2'd1;

    localparam logic [VAL_W-1:0] MISSING_RST = 32'h8000_0000;

endpackage

[rtl/per_cell_period_mean_sum.sv]
// Per-cell temporal mean / scaled-sum aggregator over a grid of NUM_CELLS cells.
// Input channel (i_in_valid / o_in_ready): cmd 0 accumulates i_sample into the
// sum and count of i_cell_index unless it equals the missing code or the count
// is full; cmd 1 reads the cell out, returns one result and clears the cell.
// Output channel (o_out_valid / i_out_ready) carries o_out_cell, o_agg_value,
// o_no_data; accumulates return nothing.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 mode,
// 1 missing code). The user must write it only while the block is idle; the
// block itself does not enforce this.
// Items are handled one at a time through a read-modify-write of the cell
// memory, whose read is registered. An accumulate passes through S_RD only.
// A readout passes S_RD, S_MUL, S_DIV (the one-bit-per-cycle restoring
// divider), S_FIN and S_DONE; an empty or out-of-range cell skips to S_DONE.
// After reset o_in_ready is low while memory is zeroed, one cell per cycle.
// A finished result waits in the output register; the next item is still
// accepted, and a following readout holds in its last step until the output
// register is free.
module per_cell_period_mean_sum
    import pcpms_pkg::*;
#(
    parameter int NUM_CELLS = NUM_CELLS_DEF,
    parameter int COUNT_MAX = COUNT_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [CELL_W-1:0]    i_cell_index,
    input  logic [VAL_W-1:0]     i_sample,
    input  logic                 i_period_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CELL_W-1:0]    o_out_cell,
    output logic [VAL_W-1:0]     o_agg_value,
    output logic                 o_no_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int DW = SUM_W + CW;
    localparam int SW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_MUL, S_DIV, S_FIN, S_DONE
    } t_state;

    t_state r_state;

    logic [SUM_W-1:0] r_sum_mem [NUM_CELLS];
    logic [CW-1:0]    r_cnt_mem [NUM_CELLS];
    logic [SUM_W-1:0] r_rd_sum;
    logic [CW-1:0]    r_rd_cnt;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [SUM_W-1:0] mem_wsum;
    logic [CW-1:0]    mem_wcnt;
    logic [AW-1:0]    mem_ra;

    logic             r_mode;
    logic [VAL_W-1:0] r_missing;
    logic [CW-1:0]    r_max;
    logic [AW-1:0]    r_clr;

    logic              r_cmd;
    logic [CELL_W-1:0] r_cell;
    logic [VAL_W-1:0]  r_sample;
    logic              r_pend;
    logic              r_cell_ok;
    logic [AW-1:0]     r_addr;

    logic             r_neg;
    logic [SUM_W-1:0] r_mag;
    logic [CW-1:0]    r_div;
    logic [DW-1:0]    r_quo;
    logic [CW-1:0]    r_rem;
    logic [SW-1:0]    r_step;
    logic [VAL_W-1:0] r_res;
    logic             r_res_nd;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_cell;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_nd;

    logic             in_xfer;
    logic             out_free;
    logic [31:0]      in_cell_wide;
    logic             in_cell_ok;
    logic             acc_ok;
    logic [SUM_W-1:0] acc_sum;
    logic [CW-1:0]    acc_cnt;
    logic [CW:0]      rem_sh;
    logic             rem_ge;
    logic [CW-1:0]    n_mult;
    logic [VAL_W-1:0] n_sat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_cell  = r_out_cell;
    assign o_agg_value = r_out_value;
    assign o_no_data   = r_out_nd;

    assign in_cell_wide = {{(32-CELL_W){1'b0}}, i_cell_index};
    assign in_cell_ok   = in_cell_wide < 32'(NUM_CELLS);
    assign mem_ra       = in_cell_wide[AW-1:0];

    assign acc_ok  = r_cell_ok && (r_sample != r_missing) && (r_rd_cnt < CW'(COUNT_MAX));
    assign acc_sum = r_rd_sum + {{(SUM_W-VAL_W){r_sample[VAL_W-1]}}, r_sample};
    assign acc_cnt = r_rd_cnt + CW'(1);

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};
    assign n_mult = (r_mode == MODE_SUM) ? r_max : CW'(1);

    always_comb begin
        if (r_neg) begin
            n_sat = (r_quo > DW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                         : VAL_W'(~r_quo + DW'(1));
        end else begin
            n_sat = (r_quo > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_quo[VAL_W-1:0];
        end
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_addr;
        mem_wsum = '0;
        mem_wcnt = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            S_RD: begin
                if (r_cmd == CMD_ACC) begin
                    mem_we   = acc_ok;
                    mem_wsum = acc_sum;
                    mem_wcnt = acc_cnt;
                end else begin
                    mem_we = r_cell_ok;
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sum_mem[mem_wa] <= mem_wsum;
            r_cnt_mem[mem_wa] <= mem_wcnt;
        end
        r_rd_sum <= r_sum_mem[mem_ra];
        r_rd_cnt <= r_cnt_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_mode      <= MODE_AVG;
            r_missing   <= MISSING_RST;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_AGG_MODE) begin
                    r_mode <= i_cfg_data[0];
                end else if (i_cfg_idx == REG_MISSING) begin
                    r_missing <= i_cfg_data;
                end
            end
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NUM_CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd     <= i_cmd;
                        r_cell    <= i_cell_index;
                        r_sample  <= i_sample;
                        r_pend    <= i_period_end;
                        r_cell_ok <= in_cell_ok;
                        r_addr    <= mem_ra;
                        r_state   <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_cmd == CMD_ACC) begin
                        if (acc_ok && acc_cnt > r_max) begin
                            r_max <= acc_cnt;
                        end
                        r_state <= S_IDLE;
                    end else if (!r_cell_ok || r_rd_cnt == '0) begin
                        r_res    <= '0;
                        r_res_nd <= 1'b1;
                        if (r_pend) begin
                            r_max <= '0;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_neg   <= r_rd_sum[SUM_W-1];
                        r_mag   <= r_rd_sum[SUM_W-1] ? (~r_rd_sum + SUM_W'(1)) : r_rd_sum;
                        r_div   <= r_rd_cnt;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_quo  <= DW'(r_mag) * DW'(n_mult);
                    r_rem  <= '0;
                    r_step <= '0;
                    if (r_pend) begin
                        r_max <= '0;
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? CW'(rem_sh - {1'b0, r_div}) : rem_sh[CW-1:0];
                    r_quo  <= {r_quo[DW-2:0], rem_ge};
                    r_step <= r_step + SW'(1);
                    if (r_step == SW'(DW - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res    <= n_sat;
                    r_res_nd <= 1'b0;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_cell  <= r_cell;
                        r_out_value <= r_res;
                        r_out_nd    <= r_res_nd;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "per_cell_period_mean_sum_defines.svh"

    `PCPMS_ASSERT_NOW(a_nodata_zero, r_out_valid && r_out_nd, r_out_value == '0)
    `PCPMS_ASSERT_NOW(a_max_bound, 1'b1, r_max <= CW'(COUNT_MAX))
    `PCPMS_ASSERT_NEXT(a_acc_silent, in_xfer && i_cmd == CMD_ACC && !r_out_valid, !r_out_valid)

endmodule
